// ===== hdl/c2ns_pkg.sv =====
// Shared types and constants for the counter to nanoseconds converter.
package c2ns_pkg;

  localparam int DIV1_STAGES = 64;
  localparam int DIV2_STAGES = 30;

  localparam logic [29:0] NS_PER_SEC = 30'd1000000000;
  localparam logic [63:0] SECS_MAX   = 64'd18446744073;
  localparam logic [63:0] ALL_ONES   = {64{1'b1}};

  typedef enum logic [1:0] {
    REG_FREQ = 2'd0,
    REG_BOOT = 2'd1
  } reg_idx_t;

  typedef struct packed {
    logic        cmd;
    logic        fz;
    logic        sat;
    logic [31:0] div;
    logic [31:0] rem;
    logic [63:0] quo;
    logic [63:0] num;
    logic [63:0] whole;
  } item_t;

endpackage

// ===== hdl/c2ns_div_stage.sv =====
// One registered restoring-division step: shifts in one dividend bit.
module c2ns_div_stage import c2ns_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  en,
  input  logic  in_vld,
  input  item_t in_item,
  output logic  out_vld,
  output item_t out_item
);

  logic  vld_r;
  item_t item_r;
  item_t item_nxt;
  logic [32:0] trial;
  logic [32:0] diff;

  always_comb begin
    trial    = {in_item.rem, in_item.num[63]};
    diff     = trial - {1'b0, in_item.div};
    item_nxt = in_item;
    item_nxt.num = {in_item.num[62:0], 1'b0};
    if (!diff[32]) begin
      item_nxt.rem = diff[31:0];
      item_nxt.quo = {in_item.quo[62:0], 1'b1};
    end else begin
      item_nxt.rem = trial[31:0];
      item_nxt.quo = {in_item.quo[62:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      item_r <= item_nxt;
    end
  end

  assign out_vld  = vld_r;
  assign out_item = item_r;

endmodule

// ===== hdl/c2ns_mul_stage.sv =====
// Registered stage: seconds scaling, overflow check and setup of the fraction divide.
module c2ns_mul_stage import c2ns_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  en,
  input  logic  in_vld,
  input  item_t in_item,
  output logic  out_vld,
  output item_t out_item
);

  logic  vld_r;
  item_t item_r;
  item_t item_nxt;
  logic [63:0] whole_prod;
  logic [61:0] frac_prod;

  always_comb begin
    whole_prod = {29'd0, in_item.quo[34:0]} * {34'd0, NS_PER_SEC};
    frac_prod  = {30'd0, in_item.rem} * {32'd0, NS_PER_SEC};
    item_nxt   = in_item;
    item_nxt.sat = (in_item.quo > SECS_MAX);
    if (in_item.cmd) begin
      item_nxt.whole = (in_item.quo == 64'd0) ? 64'd1 : in_item.quo;
    end else begin
      item_nxt.whole = whole_prod;
    end
    item_nxt.rem = frac_prod[61:30];
    item_nxt.num = {frac_prod[29:0], 34'd0};
    item_nxt.quo = 64'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      item_r <= item_nxt;
    end
  end

  assign out_vld  = vld_r;
  assign out_item = item_r;

endmodule

// ===== hdl/counter_to_nanoseconds_core.sv =====
// Counter reading to nanoseconds and tick interval converter, top level.
// Stages: input register, 64 quotient steps, scaling stage, 30 fraction steps,
// output register.
// Throughput: one request per cycle unless the whole pipeline holds, which it
// does while out_stall is high with out_valid set. Reset: synchronous active-low
// rst_n clears valid bits and sets freq_r and boot_r to zero.
module counter_to_nanoseconds_core import c2ns_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_cmd,
  input  logic [63:0] in_counter_now,
  input  logic [31:0] in_tick_rate,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_value,
  output logic        out_saturated,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  logic [31:0] freq_r;
  logic [63:0] boot_r;
  logic        en;
  logic        s0_vld_r;
  item_t       s0_item_r;
  item_t       s0_nxt;

  logic  d1_vld  [DIV1_STAGES+1];
  item_t d1_item [DIV1_STAGES+1];
  logic  d2_vld  [DIV2_STAGES+1];
  item_t d2_item [DIV2_STAGES+1];

  logic        out_valid_r;
  logic [63:0] out_value_r;
  logic        out_sat_r;
  logic [63:0] value_nxt;
  logic        sat_nxt;
  logic [64:0] sum;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      freq_r <= 32'd0;
      boot_r <= 64'd0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_FREQ: freq_r <= cfg_data[31:0];
        REG_BOOT: boot_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign en       = !(out_valid_r && out_stall);
  assign in_stall = !en;

  always_comb begin
    s0_nxt       = '0;
    s0_nxt.cmd   = in_cmd;
    s0_nxt.fz    = (freq_r == 32'd0);
    if (in_cmd) begin
      s0_nxt.div = (in_tick_rate == 32'd0) ? 32'd1 : in_tick_rate;
      s0_nxt.num = {32'd0, freq_r};
    end else begin
      s0_nxt.div = freq_r;
      s0_nxt.num = in_counter_now - boot_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else if (en) begin
      s0_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_item_r <= s0_nxt;
    end
  end

  assign d1_vld[0]  = s0_vld_r;
  assign d1_item[0] = s0_item_r;

  for (genvar i = 0; i < DIV1_STAGES; i++) begin : g_div1
    c2ns_div_stage u_stage (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .in_vld   (d1_vld[i]),
      .in_item  (d1_item[i]),
      .out_vld  (d1_vld[i+1]),
      .out_item (d1_item[i+1])
    );
  end

  c2ns_mul_stage u_mul (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (d1_vld[DIV1_STAGES]),
    .in_item  (d1_item[DIV1_STAGES]),
    .out_vld  (d2_vld[0]),
    .out_item (d2_item[0])
  );

  for (genvar j = 0; j < DIV2_STAGES; j++) begin : g_div2
    c2ns_div_stage u_stage (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .in_vld   (d2_vld[j]),
      .in_item  (d2_item[j]),
      .out_vld  (d2_vld[j+1]),
      .out_item (d2_item[j+1])
    );
  end

  always_comb begin
    sum = {1'b0, d2_item[DIV2_STAGES].whole}
        + {35'd0, d2_item[DIV2_STAGES].quo[29:0]};
    if (d2_item[DIV2_STAGES].fz) begin
      value_nxt = 64'd0;
      sat_nxt   = 1'b0;
    end else if (d2_item[DIV2_STAGES].cmd) begin
      value_nxt = d2_item[DIV2_STAGES].whole;
      sat_nxt   = 1'b0;
    end else if (d2_item[DIV2_STAGES].sat || sum[64]) begin
      value_nxt = ALL_ONES;
      sat_nxt   = 1'b1;
    end else begin
      value_nxt = sum[63:0];
      sat_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= d2_vld[DIV2_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_value_r <= value_nxt;
      out_sat_r   <= sat_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_value     = out_value_r;
  assign out_saturated = out_sat_r;

endmodule

// ===== tb/sv/tb_counter_to_nanoseconds_core.sv =====
// Testbench for the counter to nanoseconds core: directed and randomized requests, scoreboard prediction.
`timescale 1ns / 1ps

module tb_counter_to_nanoseconds_core import c2ns_pkg::*;;

  localparam int LATENCY = 96;
  localparam longint CYCLE_LIMIT = 64'd3000000;

  typedef struct {
    logic [63:0] value;
    logic        saturated;
  } ns_result_t;

  int mismatches = 0;

  task automatic report_mismatch(input string what);
    $display("[%0t] error: %s", $time, what);
    mismatches++;
  endtask

  class ns_scoreboard;
    logic [31:0] freq;
    logic [63:0] boot;
    ns_result_t  pending[$];

    function new();
      freq = '0;
      boot = '0;
    endfunction

    function void write_reg(reg_idx_t idx, logic [63:0] data);
      if (idx == REG_FREQ) freq = data[31:0];
      else if (idx == REG_BOOT) boot = data;
    endfunction

    function ns_result_t convert(logic cmd, logic [63:0] now, logic [31:0] rate);
      ns_result_t r;
      logic [63:0] f, elapsed, secs, rest, whole, part, q, rt;
      r.value = '0;
      r.saturated = 1'b0;
      f = {32'd0, freq};
      if (f == 0) return r;
      if (cmd == 1'b0) begin
        elapsed = now - boot;
        secs = elapsed / f;
        rest = elapsed - secs * f;
        if (secs > (64'hFFFF_FFFF_FFFF_FFFF / 64'd1000000000)) begin
          r.value = '1;
          r.saturated = 1'b1;
          return r;
        end
        whole = secs * 64'd1000000000;
        part = (rest * 64'd1000000000) / f;
        if ((64'hFFFF_FFFF_FFFF_FFFF - whole) < part) begin
          r.value = '1;
          r.saturated = 1'b1;
          return r;
        end
        r.value = whole + part;
      end else begin
        rt = (rate == 0) ? 64'd1 : {32'd0, rate};
        q = f / rt;
        r.value = (q == 0) ? 64'd1 : q;
      end
      return r;
    endfunction

    function void note_request(logic cmd, logic [63:0] now, logic [31:0] rate);
      pending.push_back(convert(cmd, now, rate));
    endfunction

    task check_result(logic [63:0] value, logic sat);
      ns_result_t e;
      if (pending.size() == 0) begin
        report_mismatch($sformatf("unexpected result value=%h", value));
        return;
      end
      e = pending.pop_front();
      if (value !== e.value)
        report_mismatch($sformatf("value %h, want %h", value, e.value));
      if (sat !== e.saturated)
        report_mismatch($sformatf("saturated %b, want %b", sat, e.saturated));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_cmd = 1'b0;
  logic [63:0] in_counter_now = '0;
  logic [31:0] in_tick_rate = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [63:0] out_value;
  logic        out_saturated;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;

  counter_to_nanoseconds_core u_top (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  ns_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  longint cycles = 0;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall)
      sb.note_request(in_cmd, in_counter_now, in_tick_rate);
    if (rst_n && out_valid && !out_stall)
      sb.check_result(out_value, out_saturated);
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  task automatic send_request(input logic cmd, input logic [63:0] now,
                              input logic [31:0] rate);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_counter_now <= now;
    in_tick_rate <= rate;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [63:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_request();
    logic [63:0] now;
    logic [31:0] rate;
    case ($urandom_range(5))
      0: now = sb.boot + {32'd0, $urandom()};
      1: now = sb.boot + ({32'd0, $urandom()} * {32'd0, sb.freq});
      2: now = sb.boot - {32'd0, $urandom_range(3)};
      default: now = rand64();
    endcase
    case ($urandom_range(3))
      0: rate = $urandom_range(2);
      1: rate = sb.freq + $urandom_range(2) - 1;
      default: rate = $urandom();
    endcase
    send_request(1'($urandom_range(1)), now, rate);
  endtask

  task automatic directed_set();
    send_request(1'b0, sb.boot, 32'd0);
    send_request(1'b0, sb.boot - 1, 32'd0);
    send_request(1'b0, '1, '1);
    send_request(1'b0, '0, '0);
    send_request(1'b0, sb.boot + 64'd18446744073 * sb.freq, 32'd0);
    send_request(1'b0, sb.boot + 64'd18446744074 * sb.freq, 32'd0);
    send_request(1'b0, sb.boot + 64'd18446744073 * sb.freq + sb.freq - 1, 32'd0);
    send_request(1'b1, '0, 32'd0);
    send_request(1'b1, '1, 32'd1);
    send_request(1'b1, '0, '1);
    send_request(1'b1, '0, sb.freq);
    send_request(1'b1, '0, sb.freq + 1);
  endtask

  logic [31:0] freqs[6] = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'd1000000000,
                           32'd19200000, 32'd3};
  logic [63:0] boots[6] = '{64'd0, '1, 64'd0, 64'h8000_0000_0000_0000,
                           64'd123456789, 64'd0};

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    directed_set();
    drain();
    for (int ph = 0; ph < 8; ph++) begin
      send_idle_pct = (ph % 4 == 1) ? 78 : (ph % 4 == 3) ? 24 : 0;
      recv_stall_pct = (ph % 4 == 2) ? 78 : (ph % 4 == 3) ? 24 : 0;
      write_reg(REG_FREQ, (ph < 6) ? {32'd0, freqs[ph]} : {rand64()});
      write_reg(REG_BOOT, (ph < 6) ? boots[ph] : rand64());
      write_reg(reg_idx_t'(2'd3), rand64());
      if (ph == 2 || ph == 3) directed_set();
      for (int i = 0; i < 210; i++) begin
        random_request();
        if (i == 100 && ph == 4) begin
          in_valid <= 1'b0;
          while (sb.pending.size() != 0) @(posedge clk);
        end
      end
      drain();
    end
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
